// ===== rtl/bdgm_pkg.sv =====
// Shared types, constants and glyph tables for the box-drawing glyph merge block.
`timescale 1ns / 1ps
package bdgm_pkg;

   // Row store geometry.
   localparam int MAX_WIDTH   = 256;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int ROW_WIDTH_W = 9;
   localparam int CNT_W       = (ADDR_W + 1 > ROW_WIDTH_W) ? ADDR_W + 1 : ROW_WIDTH_W;
   localparam int CODE_W      = 7;
   localparam int CELL_W      = CODE_W + 1;   // {mergeable, code}
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(80);

   // Glyph entry: [9] known, [8] round, [7:6] down, [5:4] right, [3:2] top, [1:0] left.
   typedef logic [9:0] entry_type;
   typedef logic [1:0] weight_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [CELL_W-1:0] cell_type;

   localparam int KNOWN_BIT = 9;
   localparam int ROUND_BIT = 8;

   typedef logic [7:0] inv_table_type [256];   // {found, code} by weight set

   function automatic entry_type e(input int l, input int t, input int r, input int d,
                                   input int ro);
      return {1'b1, 1'(ro), 2'(d), 2'(r), 2'(t), 2'(l)};
   endfunction

   localparam entry_type NO_GLYPH = 10'd0;

   localparam entry_type WEIGHT_ROM [128] = '{
      e(1,0,1,0,0), e(2,0,2,0,0), e(0,1,0,1,0), e(0,2,0,2,0),
      NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH, NO_GLYPH,
      e(0,0,1,1,0), e(0,0,2,1,0), e(0,0,1,2,0), e(0,0,2,2,0),
      e(1,0,0,1,0), e(2,0,0,1,0), e(1,0,0,2,0), e(2,0,0,2,0),
      e(0,1,1,0,0), e(0,1,2,0,0), e(0,2,1,0,0), e(0,2,2,0,0),
      e(1,1,0,0,0), e(2,1,0,0,0), e(1,2,0,0,0), e(2,2,0,0,0),
      e(0,1,1,1,0), e(0,1,2,1,0), e(0,2,1,1,0), e(0,1,1,2,0),
      e(0,2,1,2,0), e(0,2,2,1,0), e(0,1,2,2,0), e(0,2,2,2,0),
      e(1,1,0,1,0), e(2,1,0,1,0), e(1,2,0,1,0), e(1,1,0,2,0),
      e(1,2,0,2,0), e(2,2,0,1,0), e(2,1,0,2,0), e(2,2,0,2,0),
      e(1,0,1,1,0), e(2,0,1,1,0), e(1,0,2,1,0), e(2,0,2,1,0),
      e(1,0,1,2,0), e(2,0,1,2,0), e(1,0,2,2,0), e(2,0,2,2,0),
      e(1,1,1,0,0), e(2,1,1,0,0), e(1,1,2,0,0), e(2,1,2,0,0),
      e(1,2,1,0,0), e(2,2,1,0,0), e(1,2,2,0,0), e(2,2,2,0,0),
      e(1,1,1,1,0), e(2,1,1,1,0), e(1,1,2,1,0), e(2,1,2,1,0),
      e(1,2,1,1,0), e(1,1,1,2,0), e(1,2,1,2,0), e(2,2,1,1,0),
      e(1,2,2,1,0), e(2,1,1,2,0), e(1,1,2,2,0), e(2,2,2,1,0),
      e(2,1,2,2,0), e(2,2,1,2,0), e(1,2,2,2,0), e(2,2,2,2,0),
      NO_GLYPH, e(2,0,2,0,0), NO_GLYPH, e(0,2,0,2,0),
      e(3,0,3,0,0), e(0,3,0,3,0), e(0,0,3,1,0), e(0,0,1,3,0),
      e(0,0,3,3,0), e(3,0,0,1,0), e(1,0,0,3,0), e(3,0,0,3,0),
      e(0,1,3,0,0), e(0,3,1,0,0), e(0,3,3,0,0), e(3,1,0,0,0),
      e(1,3,0,0,0), e(3,3,0,0,0), e(0,1,3,1,0), e(0,3,1,3,0),
      e(0,3,3,3,0), e(3,1,0,1,0), e(1,3,0,3,0), e(3,3,0,3,0),
      e(3,0,3,1,0), e(1,0,1,3,0), e(3,0,3,3,0), e(3,1,3,0,0),
      e(1,3,1,0,0), e(3,3,3,0,0), e(3,1,3,1,0), e(1,3,1,3,0),
      e(3,3,3,3,0), e(0,0,1,1,1), e(1,0,0,1,1), e(1,1,0,0,1),
      e(0,1,1,0,1), NO_GLYPH, NO_GLYPH, NO_GLYPH,
      e(1,0,0,0,0), e(0,1,0,0,0), e(0,0,1,0,0), e(0,0,0,1,0),
      e(2,0,0,0,0), e(0,2,0,0,0), e(0,0,2,0,0), e(0,0,0,2,0),
      e(1,0,2,0,0), e(0,1,0,2,0), e(2,0,1,0,0), e(0,2,0,1,0)
   };

   // Inverse map, one table per round flag; ascending fill lets the higher code win.
   function automatic inv_table_type build_inv(input logic rnd);
      inv_table_type t;
      int i;
      for (i = 0; i < 256; i++) begin
         t[i] = 8'd0;
      end
      for (i = 0; i < 128; i++) begin
         if (WEIGHT_ROM[i][KNOWN_BIT] && (WEIGHT_ROM[i][ROUND_BIT] == rnd)) begin
            t[WEIGHT_ROM[i][7:0]] = {1'b1, CODE_W'(i)};
         end
      end
      return t;
   endfunction

   localparam inv_table_type INV_SQUARE = build_inv(1'b0);
   localparam inv_table_type INV_ROUND  = build_inv(1'b1);

   // Returns {found, code} for a known weight set.
   function automatic logic [7:0] find_glyph(input entry_type key);
      return key[ROUND_BIT] ? INV_ROUND[key[7:0]] : INV_SQUARE[key[7:0]];
   endfunction

   function automatic weight_type w_left(input entry_type x);
      return x[1:0];
   endfunction
   function automatic weight_type w_top(input entry_type x);
      return x[3:2];
   endfunction
   function automatic weight_type w_right(input entry_type x);
      return x[5:4];
   endfunction
   function automatic weight_type w_down(input entry_type x);
      return x[7:6];
   endfunction

   function automatic entry_type set_left(input entry_type x, input weight_type w);
      return {x[9:2], w};
   endfunction
   function automatic entry_type set_top(input entry_type x, input weight_type w);
      return {x[9:4], w, x[1:0]};
   endfunction
   function automatic entry_type set_right(input entry_type x, input weight_type w);
      return {x[9:6], w, x[3:0]};
   endfunction
   function automatic entry_type set_down(input entry_type x, input weight_type w);
      return {x[9:8], w, x[5:0]};
   endfunction

   // Merge unit interface.
   typedef struct packed {
      logic      do_h;
      logic      do_v;
      code_type  left_code;
      entry_type left_ent;
      code_type  top_code;
      entry_type top_ent;
      code_type  cur_code;
      entry_type cur_ent;
   } merge_in_type;

   typedef struct packed {
      code_type  left_code;
      code_type  top_code;
      code_type  cur_code;
      entry_type cur_ent;
   } merge_out_type;

endpackage

// ===== rtl/bdgm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module bdgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bdgm_merge.sv =====
// Combinational merge unit: current cell with its left, then with its upper neighbor.
`timescale 1ns / 1ps
module bdgm_merge import bdgm_pkg::*; (
   input  merge_in_type  mi,
   output merge_out_type mo
);

   entry_type   key_la, key_lb, key_ta, key_tb;
   logic [7:0]  hit_la, hit_lb, hit_ta, hit_tb;
   code_type    h_code;
   entry_type   h_ent;

   // Keys: a zero side takes the facing side's weight.
   assign key_la = set_right(mi.left_ent, w_left(mi.cur_ent));
   assign key_lb = set_left(mi.cur_ent, w_right(mi.left_ent));
   assign hit_la = find_glyph(key_la);
   assign hit_lb = find_glyph(key_lb);

   // Vertical pair sees the cell as it leaves the horizontal merge.
   assign key_ta = set_down(mi.top_ent, w_top(h_ent));
   assign key_tb = set_top(h_ent, w_down(mi.top_ent));
   assign hit_ta = find_glyph(key_ta);
   assign hit_tb = find_glyph(key_tb);

   always_comb begin
      mo.left_code = mi.left_code;
      h_code       = mi.cur_code;
      h_ent        = mi.cur_ent;
      if (mi.do_h && mi.left_ent[KNOWN_BIT] && mi.cur_ent[KNOWN_BIT]) begin
         if (w_right(mi.left_ent) == 2'd0 && w_left(mi.cur_ent) != 2'd0 && hit_la[7]) begin
            mo.left_code = hit_la[CODE_W-1:0];
         end
         if (w_left(mi.cur_ent) == 2'd0 && w_right(mi.left_ent) != 2'd0 && hit_lb[7]) begin
            h_code = hit_lb[CODE_W-1:0];
            h_ent  = key_lb;
         end
      end
   end

   always_comb begin
      mo.top_code = mi.top_code;
      mo.cur_code = h_code;
      mo.cur_ent  = h_ent;
      if (mi.do_v && mi.top_ent[KNOWN_BIT] && h_ent[KNOWN_BIT]) begin
         if (w_down(mi.top_ent) == 2'd0 && w_top(h_ent) != 2'd0 && hit_ta[7]) begin
            mo.top_code = hit_ta[CODE_W-1:0];
         end
         if (w_top(h_ent) == 2'd0 && w_down(mi.top_ent) != 2'd0 && hit_tb[7]) begin
            mo.cur_code = hit_tb[CODE_W-1:0];
            mo.cur_ent  = key_tb;
         end
      end
   end

endmodule

// ===== rtl/box_drawing_glyph_merge.sv =====
// Top level of the box-drawing glyph merge block.
`timescale 1ns / 1ps
// Box-drawing glyph merge. Takes one text cell per request in raster order and returns
// one response per cell with the updated codes of the left neighbor, the cell above and
// the cell itself. Throughput is one cell per clock with no gaps while the response side
// keeps up; the request is registered in stage 1 during the row store read, and the merge
// result goes into the output register. The rate is set by the row store, a single
// memory with one read and one write port: each cell reads its upper neighbor there,
// and the previous cell's final code is written back one cell later, so every cell
// costs exactly one read and one write. Accesses that overlap in flight are forwarded
// from the pending-cell register or from the write port. csr_wdata sets the row width
// (0 acts as 1, values above 256 act as 256); write it only while the block is idle.
// The row store needs no clearing after reset: each frame writes its first row before
// reading it.
module box_drawing_glyph_merge import bdgm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [6:0] code_offset, [7] mergeable
   input  logic                   req_tuser,   // [0] first_of_frame
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // [6:0] left_code, [7] left_changed,
                                               // [14:8] top_code, [15] top_changed,
                                               // [22:16] cell_code, [23] cell_changed
   // configuration
   input  logic                   csr_we,
   input  logic [ROW_WIDTH_W-1:0] csr_wdata    // row_width
);

   // ---------------------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------------------
   logic [ROW_WIDTH_W-1:0] row_width_ff, row_width_in;

   assign row_width_in = csr_we ? csr_wdata : row_width_ff;

   // ---------------------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------------------
   logic req_fire;
   logic s1_valid_ff, s1_valid_in;
   logic s1_adv;
   logic rsp_valid_ff, rsp_valid_in;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------------------------------------------------------------------------
   // Position tracking, at accept
   // ---------------------------------------------------------------------------------
   logic [ADDR_W-1:0] column_ff, column_in;
   logic              in_first_row_ff, in_first_row_in;
   logic [CNT_W-1:0]  rw_ext, eff, nxt;
   logic [ADDR_W-1:0] s0_col;
   logic              s0_first_row;

   always_comb begin
      rw_ext = CNT_W'(row_width_ff);
      if (rw_ext == '0) begin
         eff = CNT_W'(1);
      end else if (rw_ext > CNT_W'(MAX_WIDTH)) begin
         eff = CNT_W'(MAX_WIDTH);
      end else begin
         eff = rw_ext;
      end
   end

   always_comb begin
      // frame start wins; a column past a lowered width also opens a new row
      if (req_tuser) begin
         s0_col       = '0;
         s0_first_row = 1'b1;
      end else if (CNT_W'(column_ff) >= eff) begin
         s0_col       = '0;
         s0_first_row = 1'b0;
      end else begin
         s0_col       = column_ff;
         s0_first_row = in_first_row_ff;
      end
      nxt = CNT_W'(s0_col) + CNT_W'(1);
      if (!req_fire) begin
         column_in       = column_ff;
         in_first_row_in = in_first_row_ff;
      end else if (nxt >= eff) begin
         column_in       = '0;
         in_first_row_in = 1'b0;
      end else begin
         column_in       = nxt[ADDR_W-1:0];
         in_first_row_in = s0_first_row;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 1 registers (cell waiting on its row store read)
   // ---------------------------------------------------------------------------------
   logic [ADDR_W-1:0] s1_col_ff, s1_col_in;
   logic              s1_has_left_ff, s1_has_left_in;
   logic              s1_has_top_ff, s1_has_top_in;
   logic              s1_m_ff, s1_m_in;
   code_type          s1_code_ff, s1_code_in;
   entry_type         s1_ent_ff, s1_ent_in;
   logic              s1_byp_hit_ff, s1_byp_hit_in;
   cell_type          s1_byp_data_ff, s1_byp_data_in;

   // Pending cell: the previous cell, whose row store write waits for its right neighbor.
   cell_type          left_cell_ff, left_cell_in;
   entry_type         left_ent_ff, left_ent_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              pend_valid_ff, pend_valid_in;

   // Row store ports
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   cell_type          ram_wdata;
   cell_type          ram_rdata;

   merge_in_type      mi;
   merge_out_type     mo;
   cell_type          top_cell;

   assign s1_valid_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_comb begin
      s1_col_in      = s1_col_ff;
      s1_has_left_in = s1_has_left_ff;
      s1_has_top_in  = s1_has_top_ff;
      s1_m_in        = s1_m_ff;
      s1_code_in     = s1_code_ff;
      s1_ent_in      = s1_ent_ff;
      s1_byp_hit_in  = s1_byp_hit_ff;
      s1_byp_data_in = s1_byp_data_ff;
      if (req_fire) begin
         s1_col_in      = s0_col;
         s1_has_left_in = (s0_col != '0);
         s1_has_top_in  = !s0_first_row;
         s1_m_in        = req_tdata[7];
         s1_code_in     = req_tdata[CODE_W-1:0];
         s1_ent_in      = WEIGHT_ROM[req_tdata[CODE_W-1:0]];
         // the RAM returns old data on a same-address write; catch it here
         s1_byp_hit_in  = ram_we && (ram_waddr == s0_col);
         s1_byp_data_in = ram_wdata;
      end
   end

   // Upper neighbor: newest copy wins (pending cell, then write port, then memory).
   always_comb begin
      if (pend_valid_ff && (pend_addr_ff == s1_col_ff)) begin
         top_cell = left_cell_ff;
      end else if (s1_byp_hit_ff) begin
         top_cell = s1_byp_data_ff;
      end else begin
         top_cell = ram_rdata;
      end
   end

   always_comb begin
      mi.do_h      = s1_m_ff && s1_has_left_ff && left_cell_ff[CELL_W-1];
      mi.do_v      = s1_m_ff && s1_has_top_ff && top_cell[CELL_W-1];
      mi.left_code = left_cell_ff[CODE_W-1:0];
      mi.left_ent  = left_ent_ff;
      mi.top_code  = top_cell[CODE_W-1:0];
      mi.top_ent   = WEIGHT_ROM[top_cell[CODE_W-1:0]];
      mi.cur_code  = s1_code_ff;
      mi.cur_ent   = s1_ent_ff;
   end

   bdgm_merge u_merge (
      .mi (mi),
      .mo (mo)
   );

   // Write back the previous cell's final code as this cell leaves stage 1.
   assign ram_we    = s1_adv && pend_valid_ff;
   assign ram_waddr = pend_addr_ff;
   assign ram_wdata = {left_cell_ff[CELL_W-1], mo.left_code};

   bdgm_ram #(
      .WIDTH (CELL_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (req_fire),
      .raddr (s0_col),
      .rdata (ram_rdata)
   );

   always_comb begin
      left_cell_in  = left_cell_ff;
      left_ent_in   = left_ent_ff;
      pend_addr_in  = pend_addr_ff;
      pend_valid_in = pend_valid_ff;
      if (s1_adv) begin
         left_cell_in  = {s1_m_ff, mo.cur_code};
         left_ent_in   = mo.cur_ent;
         pend_addr_in  = s1_col_ff;
         pend_valid_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------------
   logic [23:0] rsp_data_ff, rsp_data_in;
   code_type    out_left, out_top;
   logic        out_left_chg, out_top_chg, out_cell_chg;

   always_comb begin
      out_left     = s1_has_left_ff ? mo.left_code : '0;
      out_left_chg = s1_has_left_ff && (mo.left_code != left_cell_ff[CODE_W-1:0]);
      out_top      = s1_has_top_ff ? mo.top_code : '0;
      out_top_chg  = s1_has_top_ff && (mo.top_code != top_cell[CODE_W-1:0]);
      out_cell_chg = (mo.cur_code != s1_code_ff);
      rsp_data_in  = s1_adv ? {out_cell_chg, mo.cur_code, out_top_chg, out_top,
                               out_left_chg, out_left}
                            : rsp_data_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= ROW_WIDTH_RESET;
         column_ff       <= '0;
         in_first_row_ff <= 1'b1;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pend_valid_ff   <= 1'b0;
         left_cell_ff    <= '0;
         left_ent_ff     <= NO_GLYPH;
      end else begin
         row_width_ff    <= row_width_in;
         column_ff       <= column_in;
         in_first_row_ff <= in_first_row_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         pend_valid_ff   <= pend_valid_in;
         left_cell_ff    <= left_cell_in;
         left_ent_ff     <= left_ent_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff      <= s1_col_in;
      s1_has_left_ff <= s1_has_left_in;
      s1_has_top_ff  <= s1_has_top_in;
      s1_m_ff        <= s1_m_in;
      s1_code_ff     <= s1_code_in;
      s1_ent_ff      <= s1_ent_in;
      s1_byp_hit_ff  <= s1_byp_hit_in;
      s1_byp_data_ff <= s1_byp_data_in;
      pend_addr_ff   <= pend_addr_in;
      rsp_data_ff    <= rsp_data_in;
   end

`ifndef SYNTH
   // A cell with a left neighbor finds that neighbor pending one column to its left.
   a_left_is_pending: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_has_left_ff |->
         pend_valid_ff && ((CNT_W'(pend_addr_ff) + CNT_W'(1)) == CNT_W'(s1_col_ff)))
      else $error("left neighbor not pending at the column before");

   // A cell that is not mergeable keeps its glyph.
   a_fixed_cell: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !s1_m_ff |-> mo.cur_code == s1_code_ff)
      else $error("non-mergeable cell changed");

   // A frame start lands at column zero of the first row.
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser |=> s1_valid_ff && !s1_has_top_ff && (s1_col_ff == '0))
      else $error("frame start not at top-left");

   // The row store is written only when a cell leaves stage 1.
   a_write_on_adv: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> s1_valid_ff && (!rsp_valid_ff || rsp_tready))
      else $error("row store write without a cell leaving stage 1");
`endif

endmodule
